// File: sv/bsrc_pkg.sv
// ----------------------------------------------------------------------------
// bsrc_pkg: shared types and constants for the banker's safety checker
// Item kinds, result status codes and the controller/datapath command link.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    localparam int PROCESSES_DEF = 8;
    localparam int RESOURCES_DEF = 4;
    localparam int UNIT_W        = 12;

    typedef enum logic [2:0] {
        KIND_SET_AVAIL = 3'd0,
        KIND_SET_ALLOC = 3'd1,
        KIND_SET_MAX   = 3'd2,
        KIND_STAGE     = 3'd3,
        KIND_CHECK     = 3'd4,
        KIND_SUBMIT    = 3'd5
    } kind_t;

    localparam logic [2:0] ST_WRITTEN = 3'd0;
    localparam logic [2:0] ST_SAFE    = 3'd1;
    localparam logic [2:0] ST_UNSAFE  = 3'd2;
    localparam logic [2:0] ST_EXCEEDS = 3'd3;
    localparam logic [2:0] ST_INSUFF  = 3'd4;

    localparam logic CFG_PROCS = 1'b0;
    localparam logic CFG_RES   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic table_write;  // apply the captured write kind
        logic chk_start;    // load work vector, clear done flags
        logic chk_step;     // test one process against work
        logic sub_cmp;      // compare request against need/available
        logic sub_apply;    // apply request, save old entries
        logic sub_restore;  // roll back saved entries
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fits;         // current process fits (and not done)
        logic exceeds;      // request above need
        logic insuff;       // request above available
    } dp_stat_t;

endpackage

// File: sv/bankers_safety_and_request_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_and_request_check: banker's algorithm safety/request checker
// Table writes, safety checks and request grants with rollback.
// ----------------------------------------------------------------------------
// One item at a time. Table writes and request staging pass through decode
// and give a single result. A safety check compares one process against the
// work vector per cycle, in repeated passes over the P processes in use, and
// then emits one result per process of the safe order; a submit adds compare
// and apply steps before the check and a rollback step when unsafe. Results
// leave through an output register.
module bankers_safety_and_request_check #(
    parameter int PROCESSES = bsrc_pkg::PROCESSES_DEF,
    parameter int RESOURCES = bsrc_pkg::RESOURCES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [2:0]  s_process,
    input  logic [1:0]  s_resource,
    input  logic [11:0] s_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_seq_process,
    output logic        m_last
);
    import bsrc_pkg::*;

    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    logic [3:0] pcnt_reg;
    logic [2:0] rcnt_reg;
    logic [1:0] res_reg;
    logic [11:0] amt_reg;
    logic [PW:0] nproc;
    logic [RW:0] nres;
    logic [2:0] kind_q, proc_q;
    logic [PW-1:0] cur_proc;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= 4'd8;
            rcnt_reg <= 3'd4;
        end else if (cfg_we) begin
            if (cfg_index == CFG_PROCS) pcnt_reg <= cfg_data;
            else rcnt_reg <= cfg_data[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            res_reg <= s_resource;
            amt_reg <= s_amount;
        end
    end

    // saturate counts into 1..built size
    assign nproc = (pcnt_reg == '0) ? (PW+1)'(1) :
                   (32'(pcnt_reg) > PROCESSES) ? (PW+1)'(PROCESSES) : (PW+1)'(pcnt_reg);
    assign nres  = (rcnt_reg == '0) ? (RW+1)'(1) :
                   (32'(rcnt_reg) > RESOURCES) ? (RW+1)'(RESOURCES) : (RW+1)'(rcnt_reg);

    bsrc_ctrl #(.PROCESSES(PROCESSES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_process(s_process),
        .kind_q(kind_q), .proc_q(proc_q),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_seq_process(m_seq_process), .m_last(m_last),
        .nproc(nproc), .cur_proc(cur_proc), .cmd(cmd), .stat(stat)
    );

    bsrc_datapath #(.PROCESSES(PROCESSES), .RESOURCES(RESOURCES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .kind(kind_q), .process(proc_q), .resource(res_reg), .amount(amt_reg),
        .cur_proc(cur_proc), .nres(nres)
    );

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_INSUFF) else $error("bad status");
    a_seq_only_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_SAFE |-> m_last && m_seq_process == 3'd0)
        else $error("sequence on non-safe result");
    a_no_apply_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.sub_apply && cmd.sub_restore)) else $error("apply and restore");

endmodule

// File: sv/bsrc_datapath.sv
// ----------------------------------------------------------------------------
// bsrc_datapath: resource tables, work vector and comparators
// Holds available, allocation, need and staged request; evaluates one
// process per cycle against the work vector for the safety check.
// ----------------------------------------------------------------------------
module bsrc_datapath #(
    parameter int PROCESSES = 8,
    parameter int RESOURCES = 4,
    parameter int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1,
    parameter int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bsrc_pkg::dp_cmd_t      cmd,
    output bsrc_pkg::dp_stat_t     stat,
    input  logic [2:0]             kind,
    input  logic [2:0]             process,
    input  logic [1:0]             resource,
    input  logic [11:0]            amount,
    input  logic [PW-1:0]          cur_proc,
    input  logic [RW:0]            nres
);
    import bsrc_pkg::*;

    localparam int WORK_W = UNIT_W + $clog2(PROCESSES + 1) + 1;

    logic [UNIT_W-1:0] avail_reg [RESOURCES];
    logic [UNIT_W-1:0] req_reg   [RESOURCES];
    logic [UNIT_W-1:0] alloc_reg [PROCESSES][RESOURCES];
    logic [UNIT_W-1:0] need_reg  [PROCESSES][RESOURCES];
    logic [UNIT_W-1:0] sv_alloc_reg [RESOURCES];
    logic [UNIT_W-1:0] sv_need_reg  [RESOURCES];
    logic [UNIT_W-1:0] sv_av_reg    [RESOURCES];
    logic [WORK_W-1:0] work_reg  [RESOURCES];
    logic [PROCESSES-1:0] done_reg;

    logic p_ok, r_ok;
    logic [PW-1:0] p_idx;
    logic [RW-1:0] r_idx;
    logic [UNIT_W:0] sum_w [RESOURCES];
    logic [RESOURCES-1:0] use_r, fit_r, exc_r, ins_r;

    assign p_ok  = 32'(process) < PROCESSES;
    assign r_ok  = 32'(resource) < RESOURCES;
    assign p_idx = PW'(process);
    assign r_idx = RW'(resource);

    always_comb begin
        for (int j = 0; j < RESOURCES; j++) begin
            use_r[j] = 32'(j) < 32'(nres);
            fit_r[j] = !use_r[j] ||
                (WORK_W'(need_reg[cur_proc][j]) <= work_reg[j]);
            exc_r[j] = use_r[j] && (req_reg[j] > need_reg[p_idx][j]);
            ins_r[j] = use_r[j] && (req_reg[j] > avail_reg[j]);
            sum_w[j] = {1'b0, alloc_reg[p_idx][j]} + {1'b0, req_reg[j]};
        end
        stat.fits    = !done_reg[cur_proc] && (&fit_r);
        stat.exceeds = |exc_r;
        stat.insuff  = |ins_r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= '0;
            for (int j = 0; j < RESOURCES; j++) begin
                avail_reg[j] <= '0;
                req_reg[j]   <= '0;
                for (int i = 0; i < PROCESSES; i++) begin
                    alloc_reg[i][j] <= '0;
                    need_reg[i][j]  <= '0;
                end
            end
        end else begin
            if (cmd.table_write) begin
                case (kind)
                    KIND_SET_AVAIL: if (r_ok) avail_reg[r_idx] <= amount;
                    KIND_SET_ALLOC: if (p_ok && r_ok) alloc_reg[p_idx][r_idx] <= amount;
                    KIND_SET_MAX: begin
                        if (p_ok && r_ok) begin
                            need_reg[p_idx][r_idx] <=
                                (amount > alloc_reg[p_idx][r_idx]) ?
                                amount - alloc_reg[p_idx][r_idx] : '0;
                        end
                    end
                    KIND_STAGE: if (r_ok) req_reg[r_idx] <= amount;
                    default: ;
                endcase
            end
            if (cmd.chk_start) begin
                done_reg <= '0;
                for (int j = 0; j < RESOURCES; j++) work_reg[j] <= WORK_W'(avail_reg[j]);
            end
            if (cmd.chk_step && stat.fits) begin
                done_reg[cur_proc] <= 1'b1;
                for (int j = 0; j < RESOURCES; j++)
                    work_reg[j] <= work_reg[j] + WORK_W'(alloc_reg[cur_proc][j]);
            end
            if (cmd.sub_apply) begin
                for (int j = 0; j < RESOURCES; j++) begin
                    sv_alloc_reg[j] <= alloc_reg[p_idx][j];
                    sv_need_reg[j]  <= need_reg[p_idx][j];
                    sv_av_reg[j]    <= avail_reg[j];
                    if (use_r[j]) begin
                        avail_reg[j] <= avail_reg[j] - req_reg[j];
                        need_reg[p_idx][j] <= need_reg[p_idx][j] - req_reg[j];
                        alloc_reg[p_idx][j] <= sum_w[j][UNIT_W] ? '1 : sum_w[j][UNIT_W-1:0];
                    end
                end
            end
            if (cmd.sub_restore) begin
                for (int j = 0; j < RESOURCES; j++) begin
                    alloc_reg[p_idx][j] <= sv_alloc_reg[j];
                    need_reg[p_idx][j]  <= sv_need_reg[j];
                    avail_reg[j]        <= sv_av_reg[j];
                end
            end
        end
    end

endmodule

// File: sv/bsrc_ctrl.sv
// ----------------------------------------------------------------------------
// bsrc_ctrl: sequencer for the banker's safety checker
// Captures an item, steps the safety passes, queues the safe order and
// emits results through a registered output stage.
// ----------------------------------------------------------------------------
module bsrc_ctrl #(
    parameter int PROCESSES = 8,
    parameter int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_kind,
    input  logic [2:0]           s_process,
    output logic [2:0]           kind_q,
    output logic [2:0]           proc_q,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [2:0]           m_seq_process,
    output logic                 m_last,
    input  logic [PW:0]          nproc,
    output logic [PW-1:0]        cur_proc,
    output bsrc_pkg::dp_cmd_t    cmd,
    input  bsrc_pkg::dp_stat_t   stat
);
    import bsrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CMP, S_APPLY, S_CHK_START, S_CHK_STEP,
        S_RESTORE, S_OUT_ONE, S_OUT_SEQ, S_WAIT
    } state_t;

    state_t state_reg;
    logic [2:0]    kind_reg, proc_reg;
    logic [PW-1:0] cur_reg;
    logic [PW:0]   cnt_reg, emit_reg;
    logic          moved_reg;
    logic [2:0]    order_reg [PROCESSES];
    logic          ov_reg;
    logic [2:0]    st_reg, seq_reg;
    logic [2:0]    pend_st_reg;
    logic          last_reg;
    logic [PW:0]   cur_w;
    logic          out_load;

    assign kind_q   = kind_reg;
    assign proc_q   = proc_reg;
    assign cur_proc = cur_reg;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = ov_reg;
    assign m_status = st_reg;
    assign m_seq_process = seq_reg;
    assign m_last   = last_reg;
    assign cur_w    = {1'b0, cur_reg};
    assign out_load = ((state_reg == S_OUT_ONE) || (state_reg == S_OUT_SEQ)) &&
                      (!ov_reg || m_ready);

    always_comb begin
        cmd = '0;
        cmd.table_write = (state_reg == S_DECODE) && (kind_reg <= KIND_STAGE);
        cmd.chk_start   = (state_reg == S_CHK_START);
        cmd.chk_step    = (state_reg == S_CHK_STEP);
        cmd.sub_apply   = (state_reg == S_APPLY);
        cmd.sub_restore = (state_reg == S_RESTORE);
        cmd.sub_cmp     = (state_reg == S_CMP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            if (out_load) ov_reg <= 1'b1;
            else if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg  <= s_kind;
                        proc_reg  <= s_process;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    pend_st_reg <= ST_WRITTEN;
                    case (kind_reg)
                        KIND_CHECK:  state_reg <= S_CHK_START;
                        KIND_SUBMIT: begin
                            if ({1'b0, proc_reg} >= 4'(nproc)) begin
                                pend_st_reg <= ST_EXCEEDS;
                                state_reg   <= S_OUT_ONE;
                            end else begin
                                state_reg <= S_CMP;
                            end
                        end
                        KIND_SET_AVAIL, KIND_SET_ALLOC, KIND_SET_MAX, KIND_STAGE:
                            state_reg <= S_OUT_ONE;
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_CMP: begin
                    if (stat.exceeds) begin
                        pend_st_reg <= ST_EXCEEDS; state_reg <= S_OUT_ONE;
                    end else if (stat.insuff) begin
                        pend_st_reg <= ST_INSUFF; state_reg <= S_OUT_ONE;
                    end else begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: state_reg <= S_CHK_START;
                S_CHK_START: begin
                    cur_reg   <= '0;
                    cnt_reg   <= '0;
                    moved_reg <= 1'b0;
                    state_reg <= S_CHK_STEP;
                end
                S_CHK_STEP: begin
                    logic [PW:0] cnt_n;
                    logic        mv_n;
                    cnt_n = cnt_reg;
                    mv_n  = moved_reg;
                    if (stat.fits) begin
                        order_reg[cnt_reg[PW-1:0]] <= 3'(cur_reg);
                        cnt_n = cnt_reg + 1'b1;
                        mv_n  = 1'b1;
                    end
                    cnt_reg <= cnt_n;
                    if (cnt_n == nproc) begin
                        emit_reg  <= '0;
                        state_reg <= S_OUT_SEQ;
                    end else if (cur_w + 1'b1 == nproc) begin
                        cur_reg   <= '0;
                        moved_reg <= 1'b0;
                        if (!mv_n) begin
                            pend_st_reg <= ST_UNSAFE;
                            state_reg <= (kind_reg == KIND_SUBMIT) ? S_RESTORE : S_OUT_ONE;
                        end
                    end else begin
                        cur_reg   <= cur_reg + 1'b1;
                        moved_reg <= mv_n;
                    end
                end
                S_RESTORE: state_reg <= S_OUT_ONE;
                S_OUT_ONE: begin
                    if (!ov_reg || m_ready) begin
                        st_reg    <= pend_st_reg;
                        seq_reg   <= '0;
                        last_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT_SEQ: begin
                    if (!ov_reg || m_ready) begin
                        st_reg   <= ST_SAFE;
                        seq_reg  <= order_reg[emit_reg[PW-1:0]];
                        last_reg <= (emit_reg + 1'b1 == nproc);
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg + 1'b1 == nproc) state_reg <= S_WAIT;
                    end
                end
                S_WAIT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
